/* src/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked only while out of reset
`define ASSERT_RUN(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every edge, reset included
`define ASSERT_ALL(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RUN(lbl, clk, rstn, prop, msg)
`define ASSERT_ALL(lbl, clk, prop, msg)
`endif
`endif

/* src/dmxcv_pkg.sv */
// types and constants of the dmx channel value generator
`default_nettype none
package dmxcv_pkg;

	localparam logic [3:0] KIND_DIMMER  = 4'd0;
	localparam logic [3:0] KIND_RED     = 4'd1;
	localparam logic [3:0] KIND_GREEN   = 4'd2;
	localparam logic [3:0] KIND_BLUE    = 4'd3;
	localparam logic [3:0] KIND_WHITE   = 4'd4;
	localparam logic [3:0] KIND_CYAN    = 4'd5;
	localparam logic [3:0] KIND_MAGENTA = 4'd6;
	localparam logic [3:0] KIND_YELLOW  = 4'd7;
	localparam logic [3:0] KIND_PAN     = 4'd8;
	localparam logic [3:0] KIND_TILT    = 4'd9;
	localparam logic [3:0] KIND_ZOOM    = 4'd10;
	localparam logic [3:0] KIND_FOCUS   = 4'd11;
	localparam logic [3:0] KIND_ZERO    = 4'd12;
	localparam logic [3:0] KIND_FULL    = 4'd13;

	localparam logic [15:0] FULL_WORD   = 16'hffff;
	localparam logic [12:0] SECTOR_UNIT = 13'd4096;

	typedef enum logic [1:0] {
		COLOR_R = 2'd0,
		COLOR_G = 2'd1,
		COLOR_B = 2'd2
	} color_t;

	typedef enum logic [1:0] {
		SEL_FULL = 2'd0,
		SEL_P    = 2'd1,
		SEL_Q    = 2'd2,
		SEL_T    = 2'd3
	} comp_sel_t;

	typedef struct packed {
		logic [3:0]  channel_kind;
		logic        fine_byte;
		logic [15:0] dimmer_level;
		logic [14:0] hue_angle;
		logic [15:0] saturation_level;
		logic [15:0] focus_level;
		logic [9:0]  slot_number;
		logic [7:0]  universe_id;
	} in_item_t;

	typedef struct packed {
		logic [8:0] slot_index;
		logic [7:0] slot_value;
		logic       slot_valid;
		logic [7:0] universe_out;
	} out_item_t;

endpackage
`default_nettype wire

/* src/dmxcv_word.sv */
// value word of one channel: hsv sector logic and level select
`default_nettype none
module dmxcv_word
	import dmxcv_pkg::*;
(
	input  wire in_item_t    item,
	output logic [15:0]      word
);

	logic [2:0]  sector;
	logic [11:0] frac;
	color_t      color;
	logic        invert;
	comp_sel_t   sel;
	logic [12:0] mult;
	logic [28:0] prod;
	logic [15:0] comp;

	assign sector = item.hue_angle[14:12];
	assign frac   = item.hue_angle[11:0];

	always_comb begin
		color  = COLOR_R;
		invert = 1'b0;
		case (item.channel_kind)
			KIND_RED: color = COLOR_R;
			KIND_GREEN: color = COLOR_G;
			KIND_BLUE: color = COLOR_B;
			KIND_CYAN: begin
				color  = COLOR_R;
				invert = 1'b1;
			end
			KIND_MAGENTA: begin
				color  = COLOR_G;
				invert = 1'b1;
			end
			KIND_YELLOW: begin
				color  = COLOR_B;
				invert = 1'b1;
			end
			default: begin
				color  = COLOR_R;
				invert = 1'b0;
			end
		endcase
	end

	// component of the chosen color in the current sector
	always_comb begin
		sel = SEL_FULL;
		case (color)
			COLOR_R: begin
				case (sector)
					3'd1: sel = SEL_Q;
					3'd2: sel = SEL_P;
					3'd3: sel = SEL_P;
					3'd4: sel = SEL_T;
					default: sel = SEL_FULL;
				endcase
			end
			COLOR_G: begin
				case (sector)
					3'd0: sel = SEL_T;
					3'd3: sel = SEL_Q;
					3'd4: sel = SEL_P;
					3'd5: sel = SEL_P;
					default: sel = SEL_FULL;
				endcase
			end
			COLOR_B: begin
				case (sector)
					3'd0: sel = SEL_P;
					3'd1: sel = SEL_P;
					3'd2: sel = SEL_T;
					3'd5: sel = SEL_Q;
					default: sel = SEL_FULL;
				endcase
			end
			default: sel = SEL_FULL;
		endcase
	end

	assign mult = (sel == SEL_Q) ? {1'b0, frac} : (SECTOR_UNIT - {1'b0, frac});
	assign prod = {13'd0, item.saturation_level} * {16'd0, mult};

	always_comb begin
		case (sel)
			SEL_P: comp = FULL_WORD - item.saturation_level;
			SEL_Q: comp = FULL_WORD - prod[27:12];
			SEL_T: comp = FULL_WORD - prod[27:12];
			default: comp = FULL_WORD;
		endcase
	end

	always_comb begin
		case (item.channel_kind)
			KIND_DIMMER: word = item.dimmer_level;
			KIND_RED: word = comp;
			KIND_GREEN: word = comp;
			KIND_BLUE: word = comp;
			KIND_CYAN: word = invert ? ~comp : comp;
			KIND_MAGENTA: word = invert ? ~comp : comp;
			KIND_YELLOW: word = invert ? ~comp : comp;
			KIND_FOCUS: word = item.focus_level;
			KIND_FULL: word = FULL_WORD;
			default: word = 16'd0;
		endcase
	end

endmodule
`default_nettype wire

/* src/dmxcv_slot.sv */
// slot range check, slot index and byte select of one channel
`default_nettype none
module dmxcv_slot
	import dmxcv_pkg::*;
#(
	parameter int UNIVERSE_SLOTS = 512
) (
	input  wire in_item_t    item,
	input  wire [15:0]       word,
	output out_item_t        result
);

	localparam logic [9:0] LAST_SLOT = 10'(UNIVERSE_SLOTS);

	logic       in_range;
	logic [9:0] index_full;
	logic [7:0] byte_sel;

	assign in_range   = (item.slot_number != 10'd0) && (item.slot_number <= LAST_SLOT);
	assign index_full = item.slot_number - 10'd1;
	assign byte_sel   = item.fine_byte ? word[7:0] : word[15:8];

	always_comb begin
		result.slot_valid   = in_range;
		result.slot_index   = in_range ? index_full[8:0] : 9'd0;
		result.slot_value   = in_range ? byte_sel : 8'd0;
		result.universe_out = item.universe_id;
	end

endmodule
`default_nettype wire

/* src/dmx_channel_value_generator.sv */
// top level of the dmx channel value generator
// usage:
//   src channel (src_valid, src_ready, src_item) takes one fixture channel per item:
//   kind, coarse/fine flag, dimmer, hue, saturation, focus, slot and universe.
//   dst channel (dst_valid, dst_ready, dst_item) returns one dmx slot item per
//   src item, in order: slot index, slot byte, slot valid flag and universe.
//   an accepted src item is loaded into the input register, then into the result
//   register through the color/level logic, which drives dst_valid; the item
//   leaves from the result register when dst_ready is high.
//   throughput is one item per cycle; both registers advance on every cycle the
//   result register is empty or taken, with the single 16x13 multiplier between them.
//   when dst_ready is low the result register holds its item and the input
//   register still takes one more item, so src_ready drops only once both
//   registers are full.
//   reset clears both valid flags: no item is held and src_ready is high.
//   there is no configuration and no state carried between items.
`default_nettype none
`include "assert_macros.svh"
module dmx_channel_value_generator
	import dmxcv_pkg::*;
#(
	parameter int UNIVERSE_SLOTS = 512
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            src_valid,
	output logic           src_ready,
	input  wire in_item_t  src_item,
	output logic           dst_valid,
	input  wire            dst_ready,
	output out_item_t      dst_item
);

	in_item_t   item_s1;
	logic       valid_s1;
	out_item_t  result_s2;
	logic       valid_s2;
	logic       advance;
	logic [15:0] word;
	out_item_t  result;

	assign advance   = !valid_s2 || dst_ready;
	assign src_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			item_s1 <= src_item;
		end
	end

	dmxcv_word u_word (
		.item (item_s1),
		.word (word)
	);

	dmxcv_slot #(
		.UNIVERSE_SLOTS (UNIVERSE_SLOTS)
	) u_slot (
		.item   (item_s1),
		.word   (word),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign dst_valid = valid_s2;
	assign dst_item  = result_s2;

	`ASSERT_RUN(a_invalid_zero, clk, arst_n, dst_valid && !dst_item.slot_valid |-> dst_item.slot_index == 9'd0 && dst_item.slot_value == 8'd0, "invalid slot item carries nonzero fields")
	`ASSERT_RUN(a_accept_fills, clk, arst_n, src_valid && src_ready |=> valid_s1, "accepted item missing from input register")
	`ASSERT_RUN(a_hold_stalled, clk, arst_n, valid_s1 && valid_s2 && !dst_ready |=> valid_s1 && valid_s2, "item dropped while output stalled")
	`ASSERT_ALL(a_reset_empty, clk, !arst_n |=> !dst_valid && !valid_s1, "item held during reset")

endmodule
`default_nettype wire

/* test/testbench.sv */
// testbench of the dmx channel value generator: predicts each slot item and checks it in order
module testbench;
	import dmxcv_pkg::*;

	localparam int UNIVERSE_SLOTS = 512;
	localparam int RANDOM_PER_PHASE = 534;
	localparam int HOLD_CYCLES = 300;
	localparam logic [3:0] KIND_SPARE_LO = 4'd14;
	localparam logic [3:0] KIND_SPARE_HI = 4'd15;

	class slot_scoreboard;
		out_item_t pending_slots[$];
		int mismatches;
		int channels_seen;
		int slots_checked;

		function new();
			mismatches = 0;
			channels_seen = 0;
			slots_checked = 0;
		endfunction

		function out_item_t predict_slot(in_item_t c);
			logic [2:0] sector;
			logic [11:0] frac;
			logic [31:0] sat;
			logic [15:0] p, q, t, r, g, b, word;
			out_item_t o;
			sector = c.hue_angle[14:12];
			frac = c.hue_angle[11:0];
			sat = 32'(c.saturation_level);
			p = FULL_WORD - c.saturation_level;
			q = FULL_WORD - 16'((sat * 32'(frac)) >> 12);
			t = FULL_WORD - 16'((sat * (32'(SECTOR_UNIT) - 32'(frac))) >> 12);
			r = FULL_WORD;
			g = FULL_WORD;
			b = FULL_WORD;
			// hue past the sixth sector stays white
			case (sector)
				3'd0: begin g = t; b = p; end
				3'd1: begin r = q; b = p; end
				3'd2: begin r = p; b = t; end
				3'd3: begin r = p; g = q; end
				3'd4: begin r = t; g = p; end
				3'd5: begin g = p; b = q; end
				default: ;
			endcase
			case (c.channel_kind)
				KIND_DIMMER:  word = c.dimmer_level;
				KIND_RED:     word = r;
				KIND_GREEN:   word = g;
				KIND_BLUE:    word = b;
				KIND_CYAN:    word = FULL_WORD - r;
				KIND_MAGENTA: word = FULL_WORD - g;
				KIND_YELLOW:  word = FULL_WORD - b;
				KIND_FOCUS:   word = c.focus_level;
				KIND_FULL:    word = FULL_WORD;
				default:      word = 16'd0;
			endcase
			o = '0;
			o.universe_out = c.universe_id;
			if (c.slot_number >= 10'd1 && int'(c.slot_number) <= UNIVERSE_SLOTS) begin
				o.slot_index = 9'(c.slot_number - 10'd1);
				o.slot_value = c.fine_byte ? word[7:0] : word[15:8];
				o.slot_valid = 1'b1;
			end
			return o;
		endfunction

		function void note_channel(in_item_t c);
			pending_slots.push_back(predict_slot(c));
			channels_seen++;
		endfunction

		function void compare_field(string label, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t mismatch %s: expected %0d actual %0d", $time, label, want, got);
				mismatches++;
			end
		endfunction

		function void check_slot(out_item_t got);
			out_item_t want;
			if (pending_slots.size() == 0) begin
				$display("%0t unexpected item: expected none actual %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_slots.pop_front();
			slots_checked++;
			compare_field("slot_index", want.slot_index, got.slot_index);
			compare_field("slot_value", want.slot_value, got.slot_value);
			compare_field("slot_valid", want.slot_valid, got.slot_valid);
			compare_field("universe_out", want.universe_out, got.universe_out);
		endfunction

		function int pending_count();
			return pending_slots.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic src_valid;
	logic src_ready;
	in_item_t src_item;
	logic dst_valid;
	logic dst_ready;
	out_item_t dst_item;

	slot_scoreboard book;
	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_req;

	dmx_channel_value_generator #(
		.UNIVERSE_SLOTS(UNIVERSE_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_item(src_item),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.dst_item(dst_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic in_item_t make_channel(logic [3:0] kind, logic fine, logic [15:0] dim,
			logic [14:0] hue, logic [15:0] sat, logic [15:0] foc, logic [9:0] slot,
			logic [7:0] uni);
		in_item_t c;
		c.channel_kind = kind;
		c.fine_byte = fine;
		c.dimmer_level = dim;
		c.hue_angle = hue;
		c.saturation_level = sat;
		c.focus_level = foc;
		c.slot_number = slot;
		c.universe_id = uni;
		return c;
	endfunction

	function automatic in_item_t random_channel();
		in_item_t c;
		c.channel_kind = 4'($urandom_range(15));
		c.fine_byte = 1'($urandom_range(1));
		c.dimmer_level = 16'($urandom);
		case ($urandom_range(9))
			0: c.hue_angle = 15'($urandom);
			1: c.hue_angle = 15'($urandom_range(6) * 4096 - $urandom_range(1));
			default: c.hue_angle = 15'($urandom_range(24575));
		endcase
		case ($urandom_range(7))
			0: c.saturation_level = 16'd0;
			1: c.saturation_level = FULL_WORD;
			default: c.saturation_level = 16'($urandom);
		endcase
		c.focus_level = 16'($urandom);
		case ($urandom_range(15))
			0: c.slot_number = 10'd0;
			1: c.slot_number = 10'($urandom_range(1023, 513));
			2: c.slot_number = $urandom_range(1) ? 10'd1 : 10'd512;
			default: c.slot_number = 10'($urandom_range(512, 1));
		endcase
		c.universe_id = 8'($urandom);
		return c;
	endfunction

	task automatic send_channel(in_item_t c);
		if ($urandom_range(99) < tx_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct)
				@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item <= c;
		do
			@(posedge clk);
		while (!src_ready);
		book.note_channel(c);
	endtask

	// output side: checks results, idles at random, and holds off on request
	initial begin
		int hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (dst_valid && dst_ready)
				book.check_slot(dst_item);
			if (hold_left > 0) begin
				hold_left--;
				dst_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				dst_ready <= 1'b0;
			end else begin
				dst_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		int ph;
		book = new();
		hold_req = 1'b0;
		tx_idle_pct = 24;
		rx_idle_pct = 83;
		arst_n = 1'b0;
		src_valid <= 1'b0;
		src_item <= '0;
		dst_ready <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_channel(make_channel(KIND_DIMMER, 1'b0, 16'hffff, 15'd0, 16'd0, 16'd0, 10'd1, 8'd0));
		send_channel(make_channel(KIND_DIMMER, 1'b1, 16'h12ab, 15'd0, 16'd0, 16'd0, 10'd512,
			8'hff));
		send_channel(make_channel(KIND_RED, 1'b0, 16'd0, 15'd0, 16'hffff, 16'd0, 10'd2, 8'd1));
		send_channel(make_channel(KIND_GREEN, 1'b0, 16'd0, 15'd4095, 16'hffff, 16'd0, 10'd3,
			8'd2));
		send_channel(make_channel(KIND_BLUE, 1'b1, 16'd0, 15'd4096, 16'h8000, 16'd0, 10'd4, 8'd3));
		send_channel(make_channel(KIND_RED, 1'b1, 16'd0, 15'd12288, 16'h1234, 16'd0, 10'd5,
			8'd4));
		send_channel(make_channel(KIND_GREEN, 1'b0, 16'd0, 15'd16484, 16'hffff, 16'd0, 10'd6,
			8'd5));
		send_channel(make_channel(KIND_BLUE, 1'b0, 16'd0, 15'd22480, 16'hffff, 16'd0, 10'd7,
			8'd6));
		send_channel(make_channel(KIND_RED, 1'b0, 16'd0, 15'd24575, 16'hffff, 16'd0, 10'd8,
			8'd7));
		// hue beyond six sectors
		send_channel(make_channel(KIND_RED, 1'b0, 16'd0, 15'd24576, 16'hffff, 16'd0, 10'd9,
			8'd8));
		send_channel(make_channel(KIND_CYAN, 1'b1, 16'd0, 15'd32767, 16'h5555, 16'd0, 10'd10,
			8'd9));
		send_channel(make_channel(KIND_CYAN, 1'b0, 16'd0, 15'd2048, 16'hffff, 16'd0, 10'd11,
			8'd10));
		send_channel(make_channel(KIND_MAGENTA, 1'b1, 16'd0, 15'd10000, 16'h9999, 16'd0, 10'd12,
			8'd11));
		send_channel(make_channel(KIND_YELLOW, 1'b0, 16'd0, 15'd0, 16'd0, 16'd0, 10'd13, 8'd12));
		send_channel(make_channel(KIND_WHITE, 1'b0, 16'hffff, 15'd100, 16'h7777, 16'hffff,
			10'd14, 8'd13));
		send_channel(make_channel(KIND_PAN, 1'b1, 16'hffff, 15'd0, 16'd0, 16'hffff, 10'd15,
			8'd14));
		send_channel(make_channel(KIND_TILT, 1'b0, 16'hffff, 15'd0, 16'd0, 16'hffff, 10'd16,
			8'd15));
		send_channel(make_channel(KIND_ZOOM, 1'b0, 16'hffff, 15'd0, 16'd0, 16'hffff, 10'd17,
			8'd16));
		send_channel(make_channel(KIND_FOCUS, 1'b1, 16'd0, 15'd0, 16'd0, 16'h00ff, 10'd18, 8'd17));
		send_channel(make_channel(KIND_ZERO, 1'b0, 16'hffff, 15'd0, 16'hffff, 16'hffff, 10'd19,
			8'd18));
		send_channel(make_channel(KIND_FULL, 1'b1, 16'd0, 15'd0, 16'd0, 16'd0, 10'd20, 8'd19));
		send_channel(make_channel(KIND_SPARE_LO, 1'b0, 16'hffff, 15'd0, 16'd0, 16'hffff, 10'd21,
			8'd20));
		send_channel(make_channel(KIND_SPARE_HI, 1'b1, 16'hffff, 15'd0, 16'd0, 16'hffff, 10'd22,
			8'd21));
		// slots outside the universe
		send_channel(make_channel(KIND_FULL, 1'b0, 16'd0, 15'd0, 16'd0, 16'd0, 10'd0, 8'd22));
		send_channel(make_channel(KIND_FULL, 1'b0, 16'd0, 15'd0, 16'd0, 16'd0, 10'd513, 8'd23));
		send_channel(make_channel(KIND_FULL, 1'b1, 16'd0, 15'd0, 16'd0, 16'd0, 10'd1023,
			8'd24));

		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 24; rx_idle_pct = 83; end
				1: begin tx_idle_pct = 83; rx_idle_pct = 24; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; hold_req = 1'b1; end
			endcase
			repeat (RANDOM_PER_PHASE)
				send_channel(random_channel());
		end
		src_valid <= 1'b0;

		while (book.pending_count() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("ran %0d channels of all kinds, %0d slot items checked, %0d mismatches",
			book.channels_seen, book.slots_checked, book.mismatches);
		$display("idle mixes: sender-light/receiver-heavy, the reverse, none, plus a long stall");
		if (book.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* dmx_channel_value_generator.f */
+incdir+src
src/dmxcv_pkg.sv
src/dmxcv_word.sv
src/dmxcv_slot.sv
src/dmx_channel_value_generator.sv
test/testbench.sv
